// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared constants, state encoding and round functions for the SHA-256
// byte stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Message length counter in bytes; the bit length is this shifted by three
  localparam int CNT_W = 61;

  // Byte position inside a block where the 64-bit length field starts
  localparam logic [5:0] LEN_POS = 6'd56;

  // Last byte position of a 64-byte block
  localparam logic [5:0] BLK_LAST = 6'h3F;

  // Padding marker byte that follows the message
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Index of the final digest word
  localparam logic [1:0] WORD_LAST = 2'd3;

  // Round index of the final round
  localparam logic [5:0] RND_LAST = 6'd63;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COMP = 5'b00010,
    S_ADD  = 5'b00100,
    S_PAD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // Initial hash values H0 to H7
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Compression sigma on the a word
  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Compression sigma on the e word
  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Schedule sigma on word t-15
  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Schedule sigma on word t-2
  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] f_ch(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    f_ch = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] f_maj(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    f_maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: one byte per input beat, digest out as four
// big-endian 64-bit beats after the end of each message.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata            | tuser            | tlast
//  --------+-----+------------------+------------------+-------------
//  in_     | in  | [7:0] data_byte  | [0] has_byte     | end_message
//  out_    | out | [63:0] digest_w. | [1:0] word_number| last_word
//
// Sequence: a byte beat that fills a block runs the 64 rounds and then the
// chaining add of the shared round unit. End of message shifts the pad bytes
// in one per cycle (up to 64, or 72 with the extra block), compresses each
// padded block, then offers 4 output beats. Input is not taken while a
// block or the digest is busy.
// Reset loads the initial hash values and clears the byte count.
// The output beats hold while out_tready is low.
//
module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_number
  output logic        out_tlast   // last_word
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   count_inc;
  logic [5:0]         pos_after;
  logic [5:0]         rnd_r, rnd_nxt;
  logic [5:0]         pad_pos_r, pad_pos_nxt;
  logic               first_r, first_nxt;
  logic               len_ok_r, len_ok_nxt;
  logic               last_blk_r, last_blk_nxt;
  logic               ending_r, ending_nxt;
  logic [1:0]         word_r, word_nxt;
  logic [31:0]        h_r [8];
  logic [31:0]        h_nxt [8];
  logic [31:0]        v_r [8];
  logic [31:0]        v_nxt [8];
  logic [31:0]        win_r [16];
  logic [31:0]        win_nxt [16];
  logic               shift_en;
  logic [7:0]         shift_byte;
  logic [7:0]         pad_byte;
  logic [63:0]        msg_bits;
  logic [63:0]        len_sh;
  logic [31:0]        t1;
  logic [31:0]        t2;
  logic [31:0]        w_new;

  // Handshake outputs straight from state
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {h_r[{word_r, 1'b0}], h_r[{word_r, 1'b1}]};
  assign out_tuser  = word_r;
  assign out_tlast  = (word_r == WORD_LAST);

  // Pad byte: marker, then zeros, then the bit length big-endian
  assign count_inc = count_r + {{(CNT_W-1){1'b0}}, 1'b1};
  assign pos_after = in_tuser ? count_inc[5:0] : count_r[5:0];
  assign msg_bits  = {count_r, 3'b000};
  assign len_sh    = msg_bits >> {~pad_pos_r[2:0], 3'b000};
  always_comb begin
    if (first_r) begin
      pad_byte = PAD_MARK;
    end else if (len_ok_r && (pad_pos_r >= LEN_POS)) begin
      pad_byte = len_sh[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Shared round unit and schedule word
  assign t1 = v_r[7] + big_sig1(v_r[4]) + f_ch(v_r[4], v_r[5], v_r[6])
              + RK[rnd_r] + win_r[0];
  assign t2 = big_sig0(v_r[0]) + f_maj(v_r[0], v_r[1], v_r[2]);
  assign w_new = sml_sig1(win_r[14]) + win_r[9] + sml_sig0(win_r[1]) + win_r[0];

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rnd_nxt      = rnd_r;
    pad_pos_nxt  = pad_pos_r;
    first_nxt    = first_r;
    len_ok_nxt   = len_ok_r;
    last_blk_nxt = last_blk_r;
    ending_nxt   = ending_r;
    word_nxt     = word_r;
    h_nxt        = h_r;
    v_nxt        = v_r;
    shift_en     = 1'b0;
    shift_byte   = 8'h00;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // Absorb the byte first, then note the end of message
          if (in_tuser) begin
            shift_en   = 1'b1;
            shift_byte = in_tdata;
            count_nxt  = count_inc;
          end
          if (in_tlast) begin
            ending_nxt  = 1'b1;
            first_nxt   = 1'b1;
            pad_pos_nxt = pos_after;
            len_ok_nxt  = (pos_after < LEN_POS);
          end
          if (in_tuser && (count_r[5:0] == BLK_LAST)) begin
            state_nxt = S_COMP;
            rnd_nxt   = '0;
            v_nxt     = h_r;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        shift_en    = 1'b1;
        shift_byte  = pad_byte;
        first_nxt   = 1'b0;
        pad_pos_nxt = pad_pos_r + 6'd1;
        if (pad_pos_r == BLK_LAST) begin
          last_blk_nxt = len_ok_r;
          state_nxt    = S_COMP;
          rnd_nxt      = '0;
          v_nxt        = h_r;
        end
      end
      S_COMP: begin
        // One round per cycle
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        if (last_blk_r) begin
          state_nxt = S_OUT;
          word_nxt  = '0;
        end else if (ending_r) begin
          // Length goes into the next block in every remaining case
          state_nxt  = S_PAD;
          len_ok_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          word_nxt = word_r + 2'd1;
          if (word_r == WORD_LAST) begin
            state_nxt    = S_IDLE;
            h_nxt        = IV;
            count_nxt    = '0;
            ending_nxt   = 1'b0;
            last_blk_nxt = 1'b0;
            first_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Block window: byte shift while filling, schedule shift while compressing
  always_comb begin
    win_nxt = win_r;
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], shift_byte};
    end else if (state_r == S_COMP) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = w_new;
    end
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      rnd_r      <= '0;
      pad_pos_r  <= '0;
      first_r    <= 1'b0;
      len_ok_r   <= 1'b0;
      last_blk_r <= 1'b0;
      ending_r   <= 1'b0;
      word_r     <= '0;
      h_r        <= IV;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rnd_r      <= rnd_nxt;
      pad_pos_r  <= pad_pos_nxt;
      first_r    <= first_nxt;
      len_ok_r   <= len_ok_nxt;
      last_blk_r <= last_blk_nxt;
      ending_r   <= ending_nxt;
      word_r     <= word_nxt;
      h_r        <= h_nxt;
    end
  end

  // Working variables and block window
  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    win_r <= win_nxt;
  end

  // Never take input while a digest is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  // Rounds advance one per cycle inside a compression
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) && (rnd_r != RND_LAST)
    |=> (state_r == S_COMP) && (rnd_r == $past(rnd_r) + 6'd1))
    else $error("round counter slipped");

  // Digest only follows a chaining add
  a_out_from_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_ADD))
    else $error("digest started without a finished block");

  // After the last digest beat the block is fresh
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast
    |=> in_tready && (count_r == '0) && (h_r[0] == IV[0]))
    else $error("state not restarted after digest");

endmodule
